// ===== src/tbm_pkg.sv =====
// Shared constants and control types for the truncated 256-bit multiplier.
// Used by tbm_ctrl, tbm_datapath, the top level and the checker.
package tbm_pkg;

  localparam int LIMB_COUNT = 8;
  localparam int LIMB_BITS  = 32;
  localparam int ADDR_W     = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;
  localparam int INDEX_W    = 3;

  typedef struct packed {
    logic              load_we;
    logic              mac_issue;
    logic              first_col;
    logic              first_row;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic              out_load;
    logic [ADDR_W-1:0] out_sel;
  } tbm_cmd_t;

endpackage

// ===== src/tbm_ctrl.sv =====
// Sequencer for the truncated multiplier: load, multiply-accumulate sweep, emit.
// Depends on tbm_pkg; drives tbm_datapath through tbm_cmd_t.
module tbm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             limb_valid,
  input  logic             load_done,
  output logic             limb_stall,
  output logic             product_valid,
  input  logic             product_stall,
  output tbm_pkg::tbm_cmd_t cmd
);

  typedef enum logic [1:0] {
    LOAD,
    MAC,
    DRAIN,
    EMIT
  } state_t;

  localparam logic [tbm_pkg::ADDR_W-1:0] LAST   = tbm_pkg::ADDR_W'(tbm_pkg::LIMB_COUNT - 1);
  localparam logic [tbm_pkg::ADDR_W:0]   LAST_W =
    (tbm_pkg::ADDR_W + 1)'(tbm_pkg::LIMB_COUNT - 1);

  state_t                    state;
  logic [tbm_pkg::ADDR_W-1:0] row;
  logic [tbm_pkg::ADDR_W-1:0] col;
  logic [tbm_pkg::ADDR_W-1:0] k;
  logic                      row_end;

  assign row_end    = ({1'b0, row} + {1'b0, col}) == LAST_W;
  assign limb_stall = (state != LOAD);

  always_comb begin
    cmd.load_we   = limb_valid && (state == LOAD);
    cmd.mac_issue = (state == MAC);
    cmd.first_col = (col == '0);
    cmd.first_row = (row == '0);
    cmd.row       = row;
    cmd.col       = col;
    cmd.out_load  = (state == EMIT) && (!product_valid || !product_stall);
    cmd.out_sel   = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= LOAD;
      row           <= '0;
      col           <= '0;
      k             <= '0;
      product_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        product_valid <= 1'b1;
      end else if (product_valid && !product_stall) begin
        product_valid <= 1'b0;
      end
      case (state)
        LOAD: begin
          if (limb_valid && load_done) begin
            state <= MAC;
            row   <= '0;
            col   <= '0;
          end
        end
        MAC: begin
          if (row_end) begin
            col <= '0;
            if (row == LAST) begin
              state <= DRAIN;
            end else begin
              row <= row + tbm_pkg::ADDR_W'(1);
            end
          end else begin
            col <= col + tbm_pkg::ADDR_W'(1);
          end
        end
        DRAIN: begin
          k     <= '0;
          state <= EMIT;
        end
        EMIT: begin
          if (cmd.out_load) begin
            if (k == LAST) begin
              state <= LOAD;
            end else begin
              k <= k + tbm_pkg::ADDR_W'(1);
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule

// ===== src/tbm_datapath.sv =====
// Operand limb stores, two-stage multiply-accumulate unit, product limbs and output word.
// Depends on tbm_pkg; commanded by tbm_ctrl.
module tbm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  tbm_pkg::tbm_cmd_t                 cmd,
  input  logic [tbm_pkg::INDEX_W-1:0]       limb_index,
  input  logic [tbm_pkg::LIMB_BITS-1:0]     a_limb,
  input  logic [tbm_pkg::LIMB_BITS-1:0]     b_limb,
  output logic [tbm_pkg::INDEX_W-1:0]       product_index,
  output logic [tbm_pkg::LIMB_BITS-1:0]     product_limb,
  output logic                              final_limb
);

  localparam int LB = tbm_pkg::LIMB_BITS;
  localparam int AW = tbm_pkg::ADDR_W;

  logic [LB-1:0]   a_store [tbm_pkg::LIMB_COUNT];
  logic [LB-1:0]   b_store [tbm_pkg::LIMB_COUNT];
  logic [LB-1:0]   acc     [tbm_pkg::LIMB_COUNT];

  logic [2*LB-1:0] prod;
  logic [AW-1:0]   s1_addr;
  logic            s1_first_col;
  logic            s1_first_row;
  logic            s1_valid;
  logic [LB-1:0]   carry;

  logic [AW-1:0]   rd_addr;
  logic [LB-1:0]   acc_rd;
  logic [2*LB-1:0] sum;

  // Row 0 writes every limb, so earlier contents never leak in.
  assign rd_addr = s1_valid ? s1_addr : cmd.out_sel;
  assign acc_rd  = acc[rd_addr];
  assign sum     = prod
                 + {{LB{1'b0}}, (s1_first_row ? '0 : acc_rd)}
                 + {{LB{1'b0}}, (s1_first_col ? '0 : carry)};

  always_ff @(posedge clk) begin
    if (cmd.load_we && (32'(limb_index) < tbm_pkg::LIMB_COUNT)) begin
      a_store[AW'(limb_index)] <= a_limb;
      b_store[AW'(limb_index)] <= b_limb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.mac_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_issue) begin
      prod         <= (2*LB)'(a_store[cmd.col]) * (2*LB)'(b_store[cmd.row]);
      s1_addr      <= cmd.row + cmd.col;
      s1_first_col <= cmd.first_col;
      s1_first_row <= cmd.first_row;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      acc[s1_addr] <= sum[LB-1:0];
      carry        <= sum[2*LB-1:LB];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      product_limb  <= acc_rd;
      product_index <= tbm_pkg::INDEX_W'(cmd.out_sel);
      final_limb    <= (cmd.out_sel == AW'(tbm_pkg::LIMB_COUNT - 1));
    end
  end

endmodule

// ===== src/truncated_256bit_multiplier.sv =====
// Truncated 256-bit multiplier top level: controller plus datapath.
// Depends on tbm_pkg, tbm_ctrl and tbm_datapath.
//
// Input channel (limb_valid / limb_stall): each word carries one 32-bit limb of
// each operand and the slot it goes to; limb_index values at or above the limb
// count are ignored. The word with load_done set starts the multiply.
// Output channel (product_valid / product_stall): eight words, product limbs
// 0..7 of the low 256 bits of A*B, final_limb set on limb 7.
// Timing: after the load_done word the 8x8 limb triangle runs through one
// 32x32 multiplier, one partial product per cycle, and on through the pipeline;
// then one product word per cycle while the receiver takes them. The multiply
// sweep dominates a full run of 8 loads.
// limb_stall is high from the load_done word until the last product word
// is placed in the output register; the next load may be taken while that
// word still waits. A stall on the output holds the word and pauses emission.
// Reset (rst, synchronous) returns to the load phase and drops any pending
// output word; stored operand limbs are not cleared.
module truncated_256bit_multiplier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          limb_valid,
  output logic                          limb_stall,
  input  logic [tbm_pkg::INDEX_W-1:0]   limb_index,
  input  logic [tbm_pkg::LIMB_BITS-1:0] a_limb,
  input  logic [tbm_pkg::LIMB_BITS-1:0] b_limb,
  input  logic                          load_done,
  output logic                          product_valid,
  input  logic                          product_stall,
  output logic [tbm_pkg::INDEX_W-1:0]   product_index,
  output logic [tbm_pkg::LIMB_BITS-1:0] product_limb,
  output logic                          final_limb
);

  tbm_pkg::tbm_cmd_t cmd;

  tbm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .limb_valid    (limb_valid),
    .load_done     (load_done),
    .limb_stall    (limb_stall),
    .product_valid (product_valid),
    .product_stall (product_stall),
    .cmd           (cmd)
  );

  tbm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .limb_index    (limb_index),
    .a_limb        (a_limb),
    .b_limb        (b_limb),
    .product_index (product_index),
    .product_limb  (product_limb),
    .final_limb    (final_limb)
  );

endmodule

// ===== src/tbm_checker.sv =====
// Port-level checks for truncated_256bit_multiplier, attached by bind.
// Depends on tbm_pkg.
module tbm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          limb_valid,
  input logic                          limb_stall,
  input logic                          load_done,
  input logic                          product_valid,
  input logic                          product_stall,
  input logic [tbm_pkg::INDEX_W-1:0]   product_index,
  input logic [tbm_pkg::LIMB_BITS-1:0] product_limb,
  input logic                          final_limb
);

  localparam logic [tbm_pkg::INDEX_W-1:0] TOP_IDX =
    tbm_pkg::INDEX_W'(tbm_pkg::LIMB_COUNT - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    product_valid && product_stall |=>
      product_valid && $stable(product_limb) && $stable(product_index)
      && $stable(final_limb))
    else $error("stalled product word changed");

  a_final_top: assert property (@(posedge clk) disable iff (rst)
    product_valid && final_limb |-> product_index == TOP_IDX)
    else $error("final word not on top limb");

  a_start_stalls: assert property (@(posedge clk) disable iff (rst)
    limb_valid && !limb_stall && load_done |=> limb_stall)
    else $error("input not stalled after start word");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !product_valid && !limb_stall)
    else $error("reset did not clear handshake");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    product_valid && !product_stall && !final_limb |=>
      product_valid |-> product_index == $past(product_index) + 3'd1)
    else $error("product words out of order");

endmodule

bind truncated_256bit_multiplier tbm_checker u_tbm_checker (
  .clk           (clk),
  .rst           (rst),
  .limb_valid    (limb_valid),
  .limb_stall    (limb_stall),
  .load_done     (load_done),
  .product_valid (product_valid),
  .product_stall (product_stall),
  .product_index (product_index),
  .product_limb  (product_limb),
  .final_limb    (final_limb)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for truncated_256bit_multiplier: loads limb pairs, predicts the low
// 256 bits of A*B per run and checks every product word. Depends on tbm_pkg.
module testbench;

  typedef struct {
    logic [tbm_pkg::INDEX_W-1:0]   index;
    logic [tbm_pkg::LIMB_BITS-1:0] limb;
    logic                          last;
  } product_word_t;

  localparam logic [tbm_pkg::LIMB_BITS-1:0] ALL_ONES = '1;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          limb_valid = 1'b0;
  logic                          limb_stall;
  logic [tbm_pkg::INDEX_W-1:0]   limb_index = '0;
  logic [tbm_pkg::LIMB_BITS-1:0] a_limb = '0;
  logic [tbm_pkg::LIMB_BITS-1:0] b_limb = '0;
  logic                          load_done = 1'b0;
  logic                          product_valid;
  logic                          product_stall = 1'b0;
  logic [tbm_pkg::INDEX_W-1:0]   product_index;
  logic [tbm_pkg::LIMB_BITS-1:0] product_limb;
  logic                          final_limb;

  logic [tbm_pkg::LIMB_BITS-1:0] op_a [tbm_pkg::LIMB_COUNT];
  logic [tbm_pkg::LIMB_BITS-1:0] op_b [tbm_pkg::LIMB_COUNT];
  product_word_t                 product_q [$];
  int                            errors = 0;
  int                            words_sent = 0;
  bit                            sender_eager = 1'b0;
  bit                            receiver_eager = 1'b0;
  int                            rx_hold = 0;

  truncated_256bit_multiplier dut (
    .clk(clk), .rst(rst),
    .limb_valid(limb_valid), .limb_stall(limb_stall),
    .limb_index(limb_index), .a_limb(a_limb), .b_limb(b_limb), .load_done(load_done),
    .product_valid(product_valid), .product_stall(product_stall),
    .product_index(product_index), .product_limb(product_limb), .final_limb(final_limb)
  );

  always #5 clk = ~clk;

  // store the limb pair; on load_done push the eight limbs of A*B mod 2^256
  task automatic predict_product(input logic [tbm_pkg::INDEX_W-1:0] idx,
                                 input logic [tbm_pkg::LIMB_BITS-1:0] a,
                                 input logic [tbm_pkg::LIMB_BITS-1:0] b,
                                 input logic last);
    logic [tbm_pkg::LIMB_COUNT*tbm_pkg::LIMB_BITS-1:0] wide_a;
    logic [tbm_pkg::LIMB_COUNT*tbm_pkg::LIMB_BITS-1:0] wide_b;
    logic [tbm_pkg::LIMB_COUNT*tbm_pkg::LIMB_BITS-1:0] prod;
    product_word_t w;
    if (idx < tbm_pkg::LIMB_COUNT) begin
      op_a[idx] = a;
      op_b[idx] = b;
    end
    if (last) begin
      for (int k = 0; k < tbm_pkg::LIMB_COUNT; k++) begin
        wide_a[k*tbm_pkg::LIMB_BITS +: tbm_pkg::LIMB_BITS] = op_a[k];
        wide_b[k*tbm_pkg::LIMB_BITS +: tbm_pkg::LIMB_BITS] = op_b[k];
      end
      prod = wide_a * wide_b;
      for (int k = 0; k < tbm_pkg::LIMB_COUNT; k++) begin
        w.index = k[tbm_pkg::INDEX_W-1:0];
        w.limb  = prod[k*tbm_pkg::LIMB_BITS +: tbm_pkg::LIMB_BITS];
        w.last  = (k == tbm_pkg::LIMB_COUNT - 1);
        product_q.push_back(w);
      end
    end
  endtask

  task automatic send_word(input logic [tbm_pkg::INDEX_W-1:0] idx,
                           input logic [tbm_pkg::LIMB_BITS-1:0] a,
                           input logic [tbm_pkg::LIMB_BITS-1:0] b,
                           input logic last);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      limb_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    limb_valid <= 1'b1;
    limb_index <= idx;
    a_limb     <= a;
    b_limb     <= b;
    load_done  <= last;
    do @(posedge clk); while (limb_stall !== 1'b0);
    predict_product(idx, a, b, last);
    words_sent++;
  endtask

  function automatic logic [tbm_pkg::LIMB_BITS-1:0] pick_limb();
    logic [tbm_pkg::LIMB_BITS-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = ALL_ONES;
      2: v = 32'h1 << $urandom_range(0, 31);
      3: v = ~(32'h1 << $urandom_range(0, 31));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic check_product_word();
    product_word_t w;
    if (product_q.size() == 0) begin
      $error("unexpected product word: index %0d limb %h", product_index, product_limb);
      errors++;
    end else begin
      w = product_q.pop_front();
      if (product_index !== w.index) begin
        $error("product_index: expected %0d, actual %0d", w.index, product_index);
        errors++;
      end
      if (product_limb !== w.limb) begin
        $error("product_limb: expected %h, actual %h", w.limb, product_limb);
        errors++;
      end
      if (final_limb !== w.last) begin
        $error("final_limb: expected %b, actual %b", w.last, final_limb);
        errors++;
      end
    end
  endtask

  // receiver: random stall before each word, plus an optional long hold
  initial begin
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        product_stall <= 1'b1;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      n = receiver_eager ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        product_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      product_stall <= 1'b0;
      do @(posedge clk); while (product_valid !== 1'b1);
      check_product_word();
    end
  end

  // zeros, then all ones: (2^256-1)^2 mod 2^256 = 1; fills every slot
  task automatic test_extremes();
    for (int k = 0; k < tbm_pkg::LIMB_COUNT; k++)
      send_word(k[tbm_pkg::INDEX_W-1:0], '0, '0, k == tbm_pkg::LIMB_COUNT - 1);
    for (int k = 0; k < tbm_pkg::LIMB_COUNT; k++)
      send_word(k[tbm_pkg::INDEX_W-1:0], ALL_ONES, ALL_ONES, k == tbm_pkg::LIMB_COUNT - 1);
  endtask

  // stores survive a run; a short run reloads only some slots
  task automatic test_partial_reload();
    send_word(3'd3, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_word(3'd0, 32'h0000_0001, ALL_ONES, 1'b1);
  endtask

  // same slot written twice, then a run started by a lone top-slot word
  task automatic test_overwrite_and_order();
    send_word(3'd5, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0);
    send_word(3'd5, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_word(3'd7, 32'h0000_0000, ALL_ONES, 1'b1);
    send_word(3'd7, ALL_ONES, 32'h0000_0002, 1'b1);
  endtask

  // hold the output long enough that the block backs up onto its input
  task automatic test_backpressure();
    sender_eager = 1'b1;
    rx_hold = 160;
    for (int r = 0; r < 3; r++) begin
      send_word(tbm_pkg::INDEX_W'($urandom_range(0, 7)), pick_limb(), pick_limb(), 1'b0);
      send_word(tbm_pkg::INDEX_W'($urandom_range(0, 7)), pick_limb(), pick_limb(), 1'b1);
    end
    sender_eager = 1'b0;
  endtask

  task automatic test_random_runs();
    int len;
    int perm [tbm_pkg::LIMB_COUNT];
    int j;
    int t;
    while (words_sent < 430) begin
      sender_eager   = ($urandom_range(0, 4) == 0);
      receiver_eager = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        // full reload in shuffled order
        for (int k = 0; k < tbm_pkg::LIMB_COUNT; k++) perm[k] = k;
        for (int k = tbm_pkg::LIMB_COUNT - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          t = perm[k]; perm[k] = perm[j]; perm[j] = t;
        end
        for (int k = 0; k < tbm_pkg::LIMB_COUNT; k++)
          send_word(tbm_pkg::INDEX_W'(perm[k]), pick_limb(), pick_limb(),
                    k == tbm_pkg::LIMB_COUNT - 1);
      end else begin
        len = $urandom_range(1, tbm_pkg::LIMB_COUNT);
        for (int k = 0; k < len; k++)
          send_word(tbm_pkg::INDEX_W'($urandom_range(0, 7)), pick_limb(), pick_limb(),
                    k == len - 1);
      end
    end
    sender_eager   = 1'b0;
    receiver_eager = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_partial_reload();
    test_overwrite_and_order();
    test_backpressure();
    test_random_runs();
    limb_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
